// ===== hw/rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/gbc_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gbc_pkg
// Types, constants and round functions of the GOST 28147-89 ECB engine.
// ---------------------------------------------------------------------------
package gbc_pkg;

  localparam int unsigned NumRounds = 32;
  localparam int unsigned RoundW    = 5;
  localparam int unsigned RotAmt    = 11;
  localparam int unsigned NumRows   = 8;
  localparam int unsigned NumKeyReg = 4;
  localparam int unsigned AddrW     = 5;

  // request codes
  localparam logic ReqBlock = 1'b0;
  localparam logic ReqTable = 1'b1;

  // key registers as eight 32-bit words, word k at bits 32k+31:32k
  typedef logic [7:0][31:0] key_words_t;
  // S-box rows, entry i of a row at bits 4i+3:4i
  typedef logic [NumRows-1:0][63:0] sbox_rows_t;

  // one word in flight through the rounds
  typedef struct packed {
    logic        dec;
    logic [31:0] n1;
    logic [31:0] n2;
  } stage_data_t;

  // key word used in a round
  function automatic logic [2:0] key_index(input logic [RoundW-1:0] rnd, input logic dec);
    logic early;
    early = dec ? (rnd < RoundW'(8)) : (rnd < RoundW'(24));
    return early ? rnd[2:0] : ~rnd[2:0];
  endfunction

  // eight nibble substitutions, then rotate left
  function automatic logic [31:0] round_fn(input sbox_rows_t rows, input logic [31:0] s);
    logic [31:0] sub;
    logic [3:0]  nib;
    sub = '0;
    for (int n = 0; n < 8; n++) begin
      nib = s[4*n +: 4];
      sub[4*n +: 4] = rows[n][4*nib +: 4];
    end
    return {sub[31-RotAmt:0], sub[31:32-RotAmt]};
  endfunction

endpackage

// ===== hw/rtl/gbc_key_regs.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gbc_key_regs
// APB-style register port holding the four 64-bit key registers.
// ---------------------------------------------------------------------------
module gbc_key_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [gbc_pkg::AddrW-1:0]   paddr,
  input  logic [63:0]                 pwdata,
  output logic [63:0]                 prdata,
  output logic                        pready,
  output gbc_pkg::key_words_t         key_words
);

  logic [gbc_pkg::NumKeyReg-1:0][63:0] key_reg;
  logic [1:0]                          reg_sel;

  // registers sit at 8-byte steps
  assign reg_sel = paddr[4:3];
  assign pready  = 1'b1;

  // write on the access cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      key_reg <= '0;
    end else if (psel && penable && pwrite) begin
      key_reg[reg_sel] <= pwdata;
    end
  end

  assign prdata    = key_reg[reg_sel];
  assign key_words = gbc_pkg::key_words_t'(key_reg);

endmodule

// ===== hw/rtl/gbc_sbox_store.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gbc_sbox_store
// Eight S-box rows, loaded one row per table-write word.
// ---------------------------------------------------------------------------
module gbc_sbox_store (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [2:0]          wr_row,
  input  logic [63:0]         wr_data,
  output gbc_pkg::sbox_rows_t rows
);

  gbc_pkg::sbox_rows_t row_q;

  // contents undefined until loaded
  always_ff @(posedge clk) begin
    if (wr_en) begin
      row_q[wr_row] <= wr_data;
    end
  end

  assign rows = row_q;

endmodule

// ===== hw/rtl/gbc_round_stage.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gbc_round_stage
// One Feistel round followed by its pipeline register.
// ---------------------------------------------------------------------------
module gbc_round_stage (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic [gbc_pkg::RoundW-1:0]   round_idx,
  input  logic                         valid_in,
  input  gbc_pkg::stage_data_t         data_in,
  input  gbc_pkg::key_words_t          key_words,
  input  gbc_pkg::sbox_rows_t          rows,
  output logic                         valid,
  output gbc_pkg::stage_data_t         data
);

  logic [31:0]          sum;
  logic [31:0]          mix;
  gbc_pkg::stage_data_t data_next;

  // add key, substitute, rotate, fold into the other half
  always_comb begin
    sum = data_in.n1 + key_words[gbc_pkg::key_index(round_idx, data_in.dec)];
    mix = data_in.n2 ^ gbc_pkg::round_fn(rows, sum);
    data_next.dec = data_in.dec;
    if (round_idx == gbc_pkg::RoundW'(gbc_pkg::NumRounds - 1)) begin
      // last round: no swap
      data_next.n1 = data_in.n1;
      data_next.n2 = mix;
    end else begin
      data_next.n1 = mix;
      data_next.n2 = data_in.n1;
    end
  end

  // valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= valid_in;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (en) begin
      data <= data_next;
    end
  end

endmodule

// ===== hw/rtl/gost_block_cipher_ecb_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gost_block_cipher_ecb_top
// GOST 28147-89 ECB engine, one round per pipeline stage.
// ---------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid/in_ready): req_type 0 carries a block in
//    block_in with decrypt choosing the key order; req_type 1 loads S-box
//    row row_index with row_data and gives no result.
//  - Output channel (out_valid/out_ready): one block_out word per block.
//  - Key registers are written over the APB-style port at 8*i, while idle.
//  - One round per stage across 32 register stages; an accepted block is
//    registered into stage 0, moves on stage by stage and drives out_valid
//    from stage 31; one block is accepted per cycle while no stage stalls.
//  - A table write waits until the rounds hold no block, so blocks in
//    flight keep the S-box contents they were accepted with.
//  - Reset clears all valid bits and the keys; S-box rows are undefined
//    until loaded and must be loaded before use.
//  - When the receiver stalls, each stage holds; empty stages still fill,
//    so input is taken until every stage is occupied.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module gost_block_cipher_ecb_top (
  input  logic                       clk,
  input  logic                       rst,
  // input channel
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       req_type,
  input  logic [63:0]                block_in,
  input  logic                       decrypt,
  input  logic [2:0]                 row_index,
  input  logic [63:0]                row_data,
  // output channel
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [63:0]                block_out,
  // configuration port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [gbc_pkg::AddrW-1:0]  paddr,
  input  logic [63:0]                pwdata,
  output logic [63:0]                prdata,
  output logic                       pready
);

  localparam int unsigned Last = gbc_pkg::NumRounds - 1;

  gbc_pkg::key_words_t                 key_words;
  gbc_pkg::sbox_rows_t                 rows;
  logic [gbc_pkg::NumRounds-1:0]       stage_valid;
  logic [gbc_pkg::NumRounds-1:0]       stage_en;
  gbc_pkg::stage_data_t                stage_data [gbc_pkg::NumRounds];
  gbc_pkg::stage_data_t                head_data;
  logic                                pipe_busy;
  logic                                block_acc;
  logic                                table_acc;

  // key registers
  gbc_key_regs u_keys (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .key_words (key_words)
  );

  // S-box rows
  gbc_sbox_store u_sbox (
    .clk     (clk),
    .wr_en   (table_acc),
    .wr_row  (row_index),
    .wr_data (row_data),
    .rows    (rows)
  );

  // input handshake; table writes only into an empty pipeline
  assign pipe_busy = |stage_valid;
  assign in_ready  = stage_en[0] && ((req_type == gbc_pkg::ReqBlock) || !pipe_busy);
  assign block_acc = in_valid && in_ready && (req_type == gbc_pkg::ReqBlock);
  assign table_acc = in_valid && in_ready && (req_type == gbc_pkg::ReqTable);

  assign head_data.dec = decrypt;
  assign head_data.n1  = block_in[31:0];
  assign head_data.n2  = block_in[63:32];

  // a stage moves when it is empty or the one after it moves
  assign stage_en[Last] = !stage_valid[Last] || out_ready;

  // round stages
  for (genvar i = 0; i < gbc_pkg::NumRounds; i++) begin : g_round
    if (i < Last) begin : g_en
      assign stage_en[i] = !stage_valid[i] || stage_en[i+1];
    end
    if (i == 0) begin : g_head
      gbc_round_stage u_stage (
        .clk       (clk),
        .rst       (rst),
        .en        (stage_en[i]),
        .round_idx (gbc_pkg::RoundW'(i)),
        .valid_in  (block_acc),
        .data_in   (head_data),
        .key_words (key_words),
        .rows      (rows),
        .valid     (stage_valid[i]),
        .data      (stage_data[i])
      );
    end else begin : g_body
      gbc_round_stage u_stage (
        .clk       (clk),
        .rst       (rst),
        .en        (stage_en[i]),
        .round_idx (gbc_pkg::RoundW'(i)),
        .valid_in  (stage_valid[i-1]),
        .data_in   (stage_data[i-1]),
        .key_words (key_words),
        .rows      (rows),
        .valid     (stage_valid[i]),
        .data      (stage_data[i])
      );
    end
  end

  // result word
  assign out_valid = stage_valid[Last];
  assign block_out = {stage_data[Last].n2, stage_data[Last].n1};

  // checks
  `ASSERT_SAME(a_table_idle, table_acc, !pipe_busy, "table write while blocks in flight")
  `ASSERT_NEXT(a_head_load, block_acc, stage_valid[0], "accepted block lost at first stage")
  `ASSERT_NEXT(a_tail_hold, out_valid && !out_ready, out_valid, "stalled result dropped")
  `ASSERT_SAME(a_full_stall, (&stage_valid) && !out_ready, !in_ready, "input taken while full")

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// GOST 28147-89 ECB engine testbench
// A directed table, then random words, against a scoreboard. The S-box rows
// are loaded before any block is sent, and blocks and row loads are mixed
// under several key settings. Both channels idle at random, and there is
// one long output stall. The key registers are written only when the
// engine is idle.
// ---------------------------------------------------------------------------
module testbench;

  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned DrainCycles = 40;
  localparam int unsigned StallLen    = 200;
  localparam int unsigned PhaseWords  = 320;

  typedef enum logic [1:0] {KEY_W01, KEY_W23, KEY_W45, KEY_W67} key_reg_t;

  // one input word, with its result where it is obvious
  typedef struct packed {
    logic        req;
    logic [63:0] blk;
    logic        dec;
    logic [2:0]  row_sel;
    logic [63:0] row_bits;
    logic        typed;
    logic [63:0] want;
  } stim_row_t;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  logic        req_type  = gbc_pkg::ReqBlock;
  logic [63:0] block_in  = '0;
  logic        decrypt   = 1'b0;
  logic [2:0]  row_index = '0;
  logic [63:0] row_data  = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [63:0] block_out;
  logic        psel      = 1'b0;
  logic        penable   = 1'b0;
  logic        pwrite    = 1'b0;
  logic [gbc_pkg::AddrW-1:0] paddr = '0;
  logic [63:0] pwdata    = '0;
  logic [63:0] prdata;
  logic        pready;

  gost_block_cipher_ecb_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .req_type  (req_type),
    .block_in  (block_in),
    .decrypt   (decrypt),
    .row_index (row_index),
    .row_data  (row_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .block_out (block_out),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // predictor state: key registers and loaded S-box rows
  logic [63:0] key_bank [4] = '{default: '0};
  logic [63:0] subst_rows [8];
  logic [63:0] block_out_q [$];
  logic [63:0] want_blk;

  int err_count   = 0;
  int blocks_seen = 0;
  int cycles      = 0;
  int stall_left  = 0;
  bit stall_done  = 1'b0;
  bit calm        = 1'b0;

  initial begin
    forever #1 clk = ~clk;
  end

  // key word for round rnd
  function automatic logic [31:0] pick_key(input int rnd, input logic dec);
    int k;
    if (!dec) k = (rnd < 24) ? (rnd % 8) : (7 - rnd % 8);
    else      k = (rnd < 8) ? rnd : (7 - rnd % 8);
    return k[0] ? key_bank[k >> 1][63:32] : key_bank[k >> 1][31:0];
  endfunction

  // add key, substitute nibbles, rotate left by 11
  function automatic logic [31:0] feistel_f(input logic [31:0] half, input logic [31:0] kw);
    logic [31:0] sum;
    logic [31:0] sub;
    logic [3:0]  nib;
    sum = half + kw;
    for (int n = 0; n < 8; n++) begin
      nib = sum[4*n +: 4];
      sub[4*n +: 4] = subst_rows[n][4*nib +: 4];
    end
    return {sub[20:0], sub[31:21]};
  endfunction

  // 32 rounds, halves swapped after all but the last
  function automatic logic [63:0] cipher_block(input logic [63:0] blk, input logic dec);
    logic [31:0] n1;
    logic [31:0] n2;
    logic [31:0] t;
    n1 = blk[31:0];
    n2 = blk[63:32];
    for (int r = 0; r < 32; r++) begin
      t = n2 ^ feistel_f(n1, pick_key(r, dec));
      if (r == 31) begin
        n2 = t;
      end else begin
        n2 = n1;
        n1 = t;
      end
    end
    return {n2, n1};
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch on %s at %0t: got %h, expected %h", what, $time, got, want);
    err_count++;
  endtask

  // offer one word and hold it until taken
  task automatic send_word(input stim_row_t w);
    if (!calm && $urandom_range(99) < 6) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    req_type  <= w.req;
    block_in  <= w.blk;
    decrypt   <= w.dec;
    row_index <= w.row_sel;
    row_data  <= w.row_bits;
    do @(posedge clk); while (!in_ready);
    if (w.req == gbc_pkg::ReqTable) subst_rows[w.row_sel] = w.row_bits;
    else block_out_q.push_back(w.typed ? w.want : cipher_block(w.blk, w.dec));
  endtask

  // stop sending, wait for every block and the pipeline tail
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (block_out_q.size() != 0);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // APB write: setup, then access
  task automatic write_key_reg(input key_reg_t sel, input logic [63:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 3'b000};
    pwdata  <= v;
    @(posedge clk) penable <= 1'b1;
    do @(posedge clk); while (!pready);
    key_bank[sel] = v;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_keys(input logic [63:0] k01, input logic [63:0] k23,
                           input logic [63:0] k45, input logic [63:0] k67);
    write_key_reg(KEY_W01, k01);
    write_key_reg(KEY_W23, k23);
    write_key_reg(KEY_W45, k45);
    write_key_reg(KEY_W67, k67);
  endtask

  // mostly blocks, the odd row reload; ignored fields carry noise
  task automatic run_random(input int count);
    stim_row_t w;
    int pick;
    for (int i = 0; i < count; i++) begin
      w.req      = ($urandom_range(11) == 0) ? gbc_pkg::ReqTable : gbc_pkg::ReqBlock;
      pick       = $urandom_range(19);
      w.blk      = (pick == 0) ? '0 : (pick == 1) ? '1 : {$urandom, $urandom};
      w.dec      = $urandom_range(1);
      w.row_sel  = $urandom_range(7);
      w.row_bits = {$urandom, $urandom};
      w.typed    = 1'b0;
      w.want     = '0;
      send_word(w);
    end
  endtask

  // output scoreboard
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (block_out_q.size() == 0) begin
        report_mismatch("block_out with none expected", block_out, '0);
      end else begin
        want_blk = block_out_q.pop_front();
        if (block_out !== want_blk) report_mismatch("block_out", block_out, want_blk);
      end
      blocks_seen <= blocks_seen + 1;
    end
  end

  // receiver: random idling, one long stall once 120 blocks have been seen
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!stall_done && blocks_seen >= 120) begin
      stall_done <= 1'b1;
      stall_left <= StallLen;
      out_ready  <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(99) >= 6);
    end
  end

  // watchdog
  initial begin
    while (cycles < CycleLimit) begin
      @(posedge clk);
      cycles++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  // stimulus
  initial begin
    stim_row_t directed [24];

    // zero rows: every round function is zero, so the halves just swap
    for (int i = 0; i < 8; i++)
      directed[i] = '{gbc_pkg::ReqTable, ~(64'h0) >> (8*i), i[0], 3'(i), 64'h0, 1'b0,
                      64'h0};
    directed[8]  = '{gbc_pkg::ReqBlock, 64'h0, 1'b0, 3'd7, 64'hFFFF_FFFF_FFFF_FFFF,
                     1'b1, 64'h0};
    directed[9]  = '{gbc_pkg::ReqBlock, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 3'd7,
                     64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF};
    directed[10] = '{gbc_pkg::ReqBlock, 64'h0123_4567_89AB_CDEF, 1'b0, 3'd0, 64'h0,
                     1'b1, 64'h89AB_CDEF_0123_4567};
    directed[11] = '{gbc_pkg::ReqBlock, 64'h8000_0000_0000_0001, 1'b1, 3'd5, 64'h1234,
                     1'b1, 64'h0000_0001_8000_0000};
    // real rows, extremes of row_data among them
    directed[12] = '{gbc_pkg::ReqTable, 64'h0, 1'b1, 3'd0, 64'hFEDC_BA98_7654_3210,
                     1'b0, 64'h0};
    directed[13] = '{gbc_pkg::ReqTable, 64'h0, 1'b0, 3'd1, 64'hFFFF_FFFF_FFFF_FFFF,
                     1'b0, 64'h0};
    directed[14] = '{gbc_pkg::ReqTable, 64'h0, 1'b0, 3'd2, 64'h0F1E_2D3C_4B5A_6978,
                     1'b0, 64'h0};
    directed[15] = '{gbc_pkg::ReqTable, 64'h0, 1'b0, 3'd3, 64'h5A0F_3C96_E1D2_B847,
                     1'b0, 64'h0};
    directed[16] = '{gbc_pkg::ReqTable, 64'h0, 1'b0, 3'd4, 64'hC3A5_F0E1_D2B4_9687,
                     1'b0, 64'h0};
    directed[17] = '{gbc_pkg::ReqTable, 64'h0, 1'b0, 3'd5, 64'h1032_5476_98BA_DCFE,
                     1'b0, 64'h0};
    directed[18] = '{gbc_pkg::ReqTable, 64'h0, 1'b0, 3'd6, 64'h7B3E_9D1C_0A5F_2864,
                     1'b0, 64'h0};
    directed[19] = '{gbc_pkg::ReqTable, 64'h0, 1'b0, 3'd7, 64'h0123_4567_89AB_CDEF,
                     1'b0, 64'h0};
    directed[20] = '{gbc_pkg::ReqBlock, 64'h0, 1'b0, 3'd0, 64'h0, 1'b0, 64'h0};
    directed[21] = '{gbc_pkg::ReqBlock, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 3'd0, 64'h0,
                     1'b0, 64'h0};
    directed[22] = '{gbc_pkg::ReqBlock, 64'h0123_4567_89AB_CDEF, 1'b0, 3'd0, 64'h0,
                     1'b0, 64'h0};
    directed[23] = '{gbc_pkg::ReqBlock, 64'h0123_4567_89AB_CDEF, 1'b1, 3'd0, 64'h0,
                     1'b0, 64'h0};

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // keys at reset value
    foreach (directed[i]) send_word(directed[i]);
    drain();

    load_keys({$urandom, $urandom}, {$urandom, $urandom},
              {$urandom, $urandom}, {$urandom, $urandom});
    run_random(PhaseWords);
    drain();

    load_keys('1, '1, '1, '1);
    run_random(PhaseWords);
    drain();

    // no idling on either side here
    calm = 1'b1;
    load_keys('0, '0, '0, '0);
    run_random(PhaseWords);
    drain();
    calm = 1'b0;

    load_keys({$urandom, $urandom}, {$urandom, $urandom},
              {$urandom, $urandom}, {$urandom, $urandom});
    run_random(PhaseWords);
    drain();

    load_keys(64'hAAAA_AAAA_5555_5555, 64'h5555_5555_AAAA_AAAA,
              64'h8000_0000_0000_0001, 64'hFFFF_FFFF_0000_0000);
    run_random(PhaseWords);
    drain();

    if (err_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
